// File: design/biq_pkg.sv
package biq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 28;
	localparam int CARRY_W   = 60;
	localparam int SUM_W     = 64;
	localparam int PROD_W    = COEF_W + SAMPLE_W;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] smp_t;
	typedef logic signed [CARRY_W-1:0]  carry_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic FORM_DF1  = 1'b0;
	localparam logic FORM_TDF2 = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0   = 3'd0,
		REG_B1   = 3'd1,
		REG_B2   = 3'd2,
		REG_A1   = 3'd3,
		REG_A2   = 3'd4,
		REG_FORM = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       saturated;
	} result_t;

	// one issue slot of the shared MAC
	typedef struct packed {
		logic en;
		logic load;
		logic neg;
		logic add_carry;
	} mac_op_t;

	typedef struct packed {
		logic                    ovf;
		logic signed [SUM_W-1:0] val;
	} sat_sum_t;

	function automatic sat_sum_t sat_add(input sum_t a, input sum_t b);
		logic [SUM_W:0] s;
		sat_sum_t       r;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		r.ovf = s[SUM_W] ^ s[SUM_W-1];
		r.val = r.ovf ? (s[SUM_W] ? SUM_MIN : SUM_MAX) : sum_t'(s[SUM_W-1:0]);
		return r;
	endfunction

endpackage

// File: design/biq_mac.sv
module biq_mac import biq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mac_op_t op,
	input  coef_t   coef,
	input  smp_t    data,
	input  sum_t    carry,
	output sum_t    acc,
	output logic    ovf
);

	logic signed [PROD_W-1:0] prod;
	sum_t                     prod_ext;
	mac_op_t                  op_s1;
	sum_t                     term_s1;
	sum_t                     addend;
	sat_sum_t                 sum;
	sum_t                     acc_q;
	logic                     ovf_q;

	assign prod     = PROD_W'(coef) * PROD_W'(data);
	assign prod_ext = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			term_s1 <= op.add_carry ? carry : prod_ext;
		end
	end

	assign addend = op_s1.neg ? -term_s1 : term_s1;
	assign sum    = sat_add(acc_q, addend);

	always_ff @(posedge clk) begin
		if (op_s1.en) begin
			acc_q <= op_s1.load ? addend : sum.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else begin
			ovf_q <= op_s1.en & ~op_s1.load & sum.ovf;
		end
	end

	assign acc = acc_q;
	assign ovf = ovf_q;

endmodule

// File: design/biquad_iir_filter_core.sv
// Biquad IIR section, signed 24-bit samples, Q3.28 coefficients.
// item channel: item_valid/item_ready with item.sample and item.restart.
//   restart clears both forms' history before the sample is filtered.
// result channel: result_valid/result_ready with result.filtered and
//   result.saturated (set on any clamp of the result or a carried accumulator).
// cfg channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   b0, b1, b2, a1, a2, form_select (0..5); other indexes are dropped.
//   Write only while no sample is in flight.
// One shared multiply-accumulate unit issues one product or carry add per
// cycle, registers the term and then the sum, and so sets the timing.
// Direct form 1: b0, b1, b2, a1, a2, wait, then the result load; transposed
// form 2: b0, c1, wait, round, b1, a1, c2, b2, a2, wait, then the result load.
// item_ready is high only while no sample is in flight.
// A held result register stalls the final step until the slot frees up;
// the next input beat is taken as soon as the result is registered.
// Reset: b0 = 1.0, other coefficients 0, form 1, all history zero.
module biquad_iir_filter_core import biq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_OP_B0, S_OP_B1, S_OP_B2, S_OP_A1, S_OP_A2, S_WAIT1, S_DONE1,
		S_T_B0, S_T_C1, S_T_W0, S_T_RND, S_T_B1, S_T_A1, S_T_C2, S_T_B2,
		S_T_A2, S_T_W1, S_DONE2
	} state_t;

	localparam sum_t ROUND_HALF = sum_t'(64'sd1 <<< (COEF_FRAC - 1));
	localparam sum_t SAMPLE_MAX = sum_t'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
	localparam sum_t SAMPLE_MIN = -SAMPLE_MAX - sum_t'(1);
	localparam sum_t CARRY_MAX  = sum_t'((64'sd1 <<< (CARRY_W - 1)) - 64'sd1);
	localparam sum_t CARRY_MIN  = -CARRY_MAX - sum_t'(1);
	localparam coef_t COEF_ONE  = coef_t'(64'sd1 <<< COEF_FRAC);

	state_t  state_q;
	coef_t   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic    form_q;
	smp_t    x_q, xp1_q, xp2_q, yp1_q, yp2_q, y_q;
	carry_t  c1_q, c2_q;
	logic    flag_q;
	logic    result_valid_q;
	result_t result_q;

	mac_op_t mac_op;
	coef_t   mac_coef;
	smp_t    mac_data;
	sum_t    mac_carry;
	sum_t    acc;
	logic    acc_ovf;

	sat_sum_t rnd;
	sum_t     rnd_val;
	sum_t     rnd_sh;
	logic     rnd_hi, rnd_lo, rnd_sat;
	smp_t     y_rnd;
	logic     car_hi, car_lo;
	carry_t   car_val;
	logic     out_free;
	logic     item_acc;
	logic     df1_busy;
	logic     res_load;
	logic     flag_add;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= COEF_ONE;
			b1_q   <= '0;
			b2_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
			form_q <= FORM_DF1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_B0:   b0_q   <= coef_t'(cfg_data);
				REG_B1:   b1_q   <= coef_t'(cfg_data);
				REG_B2:   b2_q   <= coef_t'(cfg_data);
				REG_A1:   a1_q   <= coef_t'(cfg_data);
				REG_A2:   a2_q   <= coef_t'(cfg_data);
				REG_FORM: form_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mac_op    = '0;
		mac_coef  = b0_q;
		mac_data  = x_q;
		mac_carry = {{(SUM_W-CARRY_W){c1_q[CARRY_W-1]}}, c1_q};
		case (state_q)
			S_OP_B0: mac_op = '{en: 1'b1, load: 1'b1, neg: 1'b0, add_carry: 1'b0};
			S_OP_B1: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b0, add_carry: 1'b0};
				mac_coef = b1_q;
				mac_data = xp1_q;
			end
			S_OP_B2: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b0, add_carry: 1'b0};
				mac_coef = b2_q;
				mac_data = xp2_q;
			end
			S_OP_A1: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b1, add_carry: 1'b0};
				mac_coef = a1_q;
				mac_data = yp1_q;
			end
			S_OP_A2: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b1, add_carry: 1'b0};
				mac_coef = a2_q;
				mac_data = yp2_q;
			end
			S_T_B0: mac_op = '{en: 1'b1, load: 1'b1, neg: 1'b0, add_carry: 1'b0};
			S_T_C1: mac_op = '{en: 1'b1, load: 1'b0, neg: 1'b0, add_carry: 1'b1};
			S_T_B1: begin
				mac_op   = '{en: 1'b1, load: 1'b1, neg: 1'b0, add_carry: 1'b0};
				mac_coef = b1_q;
			end
			S_T_A1: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b1, add_carry: 1'b0};
				mac_coef = a1_q;
				mac_data = y_q;
			end
			S_T_C2: begin
				mac_op    = '{en: 1'b1, load: 1'b0, neg: 1'b0, add_carry: 1'b1};
				mac_carry = {{(SUM_W-CARRY_W){c2_q[CARRY_W-1]}}, c2_q};
			end
			S_T_B2: begin
				mac_op   = '{en: 1'b1, load: 1'b1, neg: 1'b0, add_carry: 1'b0};
				mac_coef = b2_q;
			end
			S_T_A2: begin
				mac_op   = '{en: 1'b1, load: 1'b0, neg: 1'b1, add_carry: 1'b0};
				mac_coef = a2_q;
				mac_data = y_q;
			end
			default: ;
		endcase
	end

	biq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.coef   (mac_coef),
		.data   (mac_data),
		.carry  (mac_carry),
		.acc    (acc),
		.ovf    (acc_ovf)
	);

	// round half up, then clamp to sample range
	assign rnd     = sat_add(acc, ROUND_HALF);
	assign rnd_val = rnd.val;
	assign rnd_sh  = rnd_val >>> COEF_FRAC;
	assign rnd_hi  = rnd_sh > SAMPLE_MAX;
	assign rnd_lo  = rnd_sh < SAMPLE_MIN;
	assign rnd_sat = rnd.ovf | rnd_hi | rnd_lo;
	assign y_rnd   = rnd_hi ? smp_t'(SAMPLE_MAX[SAMPLE_W-1:0]) :
	                 rnd_lo ? smp_t'(SAMPLE_MIN[SAMPLE_W-1:0]) : smp_t'(rnd_sh[SAMPLE_W-1:0]);

	assign car_hi  = acc > CARRY_MAX;
	assign car_lo  = acc < CARRY_MIN;
	assign car_val = car_hi ? carry_t'(CARRY_MAX[CARRY_W-1:0]) :
	                 car_lo ? carry_t'(CARRY_MIN[CARRY_W-1:0]) : carry_t'(acc[CARRY_W-1:0]);

	assign out_free = ~result_valid_q | result_ready;
	assign item_acc = item_valid & item_ready;
	assign res_load = ((state_q == S_DONE1) || (state_q == S_DONE2)) && out_free;
	assign flag_add = acc_ovf | ((state_q == S_T_RND) & rnd_sat) |
	                  ((state_q == S_T_A2) & (car_hi | car_lo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			flag_q         <= 1'b0;
			y_q            <= '0;
			xp1_q          <= '0;
			xp2_q          <= '0;
			yp1_q          <= '0;
			yp2_q          <= '0;
			c1_q           <= '0;
			c2_q           <= '0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (state_q != S_IDLE) begin
				flag_q <= flag_q | flag_add;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						flag_q  <= 1'b0;
						state_q <= (form_q == FORM_TDF2) ? S_T_B0 : S_OP_B0;
						if (item.restart) begin
							xp1_q <= '0;
							xp2_q <= '0;
							yp1_q <= '0;
							yp2_q <= '0;
							c1_q  <= '0;
							c2_q  <= '0;
						end
					end
				end
				S_OP_B0: state_q <= S_OP_B1;
				S_OP_B1: state_q <= S_OP_B2;
				S_OP_B2: state_q <= S_OP_A1;
				S_OP_A1: state_q <= S_OP_A2;
				S_OP_A2: state_q <= S_WAIT1;
				S_WAIT1: state_q <= S_DONE1;
				S_DONE1: begin
					if (out_free) begin
						result_q.filtered  <= y_rnd;
						result_q.saturated <= flag_q | acc_ovf | rnd_sat;
						xp2_q              <= xp1_q;
						xp1_q              <= x_q;
						yp2_q              <= yp1_q;
						yp1_q              <= y_rnd;
						state_q            <= S_IDLE;
					end
				end
				S_T_B0: state_q <= S_T_C1;
				S_T_C1: state_q <= S_T_W0;
				S_T_W0: state_q <= S_T_RND;
				S_T_RND: begin
					y_q     <= y_rnd;
					state_q <= S_T_B1;
				end
				S_T_B1: state_q <= S_T_A1;
				S_T_A1: state_q <= S_T_C2;
				S_T_C2: state_q <= S_T_B2;
				S_T_B2: state_q <= S_T_A2;
				S_T_A2: begin
					c1_q    <= car_val;
					state_q <= S_T_W1;
				end
				S_T_W1: state_q <= S_DONE2;
				S_DONE2: begin
					if (out_free) begin
						c2_q               <= car_val;
						result_q.filtered  <= y_q;
						result_q.saturated <= flag_q | acc_ovf | car_hi | car_lo;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			x_q <= item.sample;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign df1_busy = (state_q == S_OP_B0) || (state_q == S_OP_B1) || (state_q == S_OP_B2) ||
	                  (state_q == S_OP_A1) || (state_q == S_OP_A2) || (state_q == S_WAIT1) ||
	                  (state_q == S_DONE1);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken while a sample is in flight");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_DONE1 || state_q == S_DONE2))
		else $error("result raised outside a final step");

	a_df1_keeps_carry: assert property (@(posedge clk) disable iff (!arst_n)
		df1_busy |=> $stable(c1_q) && $stable(c2_q))
		else $error("form 2 accumulators changed during a form 1 sample");

	a_tdf2_keeps_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T_B1 || state_q == S_T_A2) |=>
			$stable(xp1_q) && $stable(yp1_q))
		else $error("form 1 history changed during a form 2 sample");

endmodule

// File: bench/biquad_iir_filter_checker.sv
module biquad_iir_filter_checker import biq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  item_t                item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam sum_t ROUND_HALF = sum_t'(1) <<< (COEF_FRAC - 1);

	coef_t   b0, b1, b2, a1, a2;
	logic    form;
	smp_t    x_d1, x_d2, y_d1, y_d2;
	carry_t  carry1, carry2;
	logic    clamped;
	result_t due_results[$];
	result_t want;
	int      beat_no;

	function automatic sum_t prod(input coef_t c, input smp_t v);
		return sum_t'(c) * sum_t'(v);
	endfunction

	function automatic sum_t sum_sat(input sum_t a, input sum_t b);
		logic signed [SUM_W:0] s;
		s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
		if (s > SUM_MAX) begin
			clamped = 1'b1;
			return SUM_MAX;
		end
		if (s < SUM_MIN) begin
			clamped = 1'b1;
			return SUM_MIN;
		end
		return sum_t'(s);
	endfunction

	function automatic sum_t clamp_to(input sum_t v, input int w);
		sum_t hi, lo;
		hi = (sum_t'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clamped = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clamped = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// add one half, floor, saturate to sample width
	function automatic sum_t round_out(input sum_t acc);
		return clamp_to(sum_sat(acc, ROUND_HALF) >>> COEF_FRAC, SAMPLE_W);
	endfunction

	function automatic result_t filter_sample(input item_t it);
		sum_t    acc, s1, s2, y;
		result_t r;
		clamped = 1'b0;
		if (it.restart) begin
			x_d1 = '0;
			x_d2 = '0;
			y_d1 = '0;
			y_d2 = '0;
			carry1 = '0;
			carry2 = '0;
		end
		if (form == FORM_DF1) begin
			acc = prod(b0, it.sample);
			acc = sum_sat(acc, prod(b1, x_d1));
			acc = sum_sat(acc, prod(b2, x_d2));
			acc = sum_sat(acc, -prod(a1, y_d1));
			acc = sum_sat(acc, -prod(a2, y_d2));
			y = round_out(acc);
			x_d2 = x_d1;
			x_d1 = it.sample;
			y_d2 = y_d1;
			y_d1 = smp_t'(y);
		end else begin
			acc = sum_sat(prod(b0, it.sample), sum_t'(carry1));
			y = round_out(acc);
			s1 = sum_sat(prod(b1, it.sample), -prod(a1, smp_t'(y)));
			s1 = sum_sat(s1, sum_t'(carry2));
			s2 = sum_sat(prod(b2, it.sample), -prod(a2, smp_t'(y)));
			carry1 = carry_t'(clamp_to(s1, CARRY_W));
			carry2 = carry_t'(clamp_to(s2, CARRY_W));
		end
		r.filtered = smp_t'(y);
		r.saturated = clamped;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			b0 = coef_t'(1) <<< COEF_FRAC;
			b1 = '0;
			b2 = '0;
			a1 = '0;
			a2 = '0;
			form = FORM_DF1;
			x_d1 = '0;
			x_d2 = '0;
			y_d1 = '0;
			y_d2 = '0;
			carry1 = '0;
			carry2 = '0;
			due_results.delete();
			mismatches = 0;
			pending = 0;
			beat_no = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_B0:   b0 = cfg_data;
					REG_B1:   b1 = cfg_data;
					REG_B2:   b2 = cfg_data;
					REG_A1:   a1 = cfg_data;
					REG_A2:   a2 = cfg_data;
					REG_FORM: form = cfg_data[0];
					default:  ;
				endcase
			end
			// result first: a beat at the same edge belongs to an older sample
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat %0d unexpected: filtered %0d saturated %b",
							beat_no, result.filtered, result.saturated);
				end else begin
					want = due_results.pop_front();
					if (result.filtered !== want.filtered ||
							result.saturated !== want.saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result beat %0d: expected %0d/%b, got %0d/%b",
								beat_no, want.filtered, want.saturated,
								result.filtered, result.saturated);
					end
				end
				beat_no++;
			end
			if (item_valid && item_ready)
				due_results.push_back(filter_sample(item));
			pending = due_results.size();
		end
	end

endmodule

// File: bench/biquad_iir_filter_core_tb.sv
module biquad_iir_filter_core_tb import biq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam coef_t UNITY    = coef_t'(1) <<< COEF_FRAC;
	localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam smp_t  SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam smp_t  SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int RANDOM_SAMPLES = 1330;
	localparam int QUIET_TAIL     = 120;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b1;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data = '0;
	int                   mismatches;
	int                   pending;
	int                   idle_pct = 0;

	biquad_iir_filter_core dut (.*);

	biquad_iir_filter_checker filter_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#500_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				result_ready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				result_ready = 1'b1;
			end
		end
	end

	function automatic coef_t rand_coef(input coef_t span);
		return coef_t'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_sample(input smp_t s, input logic r);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid = 1'b1;
		item.sample = s;
		item.restart = r;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_filter(input coef_t c0, c1, c2, f1, f2, input logic f);
		logic [COEF_W-1:0] junk;
		junk = $urandom();
		write_reg(REG_B0, c0);
		write_reg(REG_B1, c1);
		write_reg(REG_B2, c2);
		write_reg(REG_A1, f1);
		write_reg(REG_A2, f2);
		write_reg(REG_FORM, {junk[COEF_W-1:1], f});
	endtask

	task automatic drain();
		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int    sent;
		int    n;
		coef_t c[5];
		smp_t  s;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset gain passes samples through
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample('0, 1'b0);
		send_sample(smp_t'(-1), 1'b0);
		send_sample(smp_t'(1), 1'b0);
		drain();

		// half gain on odd samples lands on rounding ties
		set_filter(UNITY / 2, 0, 0, 0, 0, FORM_DF1);
		send_sample(smp_t'(1), 1'b0);
		send_sample(smp_t'(-1), 1'b0);
		send_sample(smp_t'(3), 1'b0);
		send_sample(smp_t'(-3), 1'b0);
		drain();

		set_filter(COEF_MAX, 0, 0, 0, 0, FORM_DF1);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		drain();

		set_filter(UNITY / 4, UNITY / 2, COEF_MIN, COEF_MIN, COEF_MAX, FORM_DF1);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(smp_t'(1000), 1'b0);
		send_sample(SMP_MAX, 1'b1);
		send_sample(smp_t'(-5), 1'b0);
		drain();

		set_filter(UNITY / 4, UNITY / 2, COEF_MIN, COEF_MIN, COEF_MAX, FORM_TDF2);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(smp_t'(77), 1'b1);
		send_sample(SMP_MAX, 1'b0);
		drain();

		// unmapped indexes must leave everything alone; form 1 history resumes
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		write_reg(REG_FORM, COEF_W'(FORM_DF1));
		send_sample(smp_t'(-1234), 1'b0);
		send_sample(smp_t'(4321), 1'b0);
		drain();

		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 3))
				0: begin
					foreach (c[i]) c[i] = $urandom();
				end
				1: begin
					c[0] = rand_coef(UNITY);
					c[1] = rand_coef(UNITY);
					c[2] = rand_coef(UNITY);
					c[3] = rand_coef(UNITY);
					c[4] = rand_coef(UNITY / 2);
				end
				2: begin
					c[0] = $urandom();
					c[1] = $urandom();
					c[2] = $urandom();
					c[3] = '0;
					c[4] = '0;
				end
				default: begin
					foreach (c[i]) begin
						case ($urandom_range(0, 4))
							0:       c[i] = COEF_MIN;
							1:       c[i] = COEF_MAX;
							2:       c[i] = '0;
							3:       c[i] = UNITY;
							default: c[i] = -UNITY;
						endcase
					end
				end
			endcase
			set_filter(c[0], c[1], c[2], c[3], c[4], $urandom_range(0, 1) ? FORM_TDF2 : FORM_DF1);
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				default: idle_pct = 40;
			endcase
			n = $urandom_range(60, 140);
			repeat (n) begin
				if (sent >= RANDOM_SAMPLES)
					break;
				if (sent >= RANDOM_SAMPLES - QUIET_TAIL)
					idle_pct = 0;
				case ($urandom_range(0, 7))
					0:       s = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
					1, 2:    s = smp_t'($urandom_range(0, 510)) - smp_t'(255);
					default: s = smp_t'($urandom());
				endcase
				send_sample(s, $urandom_range(0, 39) == 0);
				sent++;
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
design/biq_pkg.sv
design/biq_mac.sv
design/biquad_iir_filter_core.sv
bench/biquad_iir_filter_checker.sv
bench/biquad_iir_filter_core_tb.sv
